// ----- hdl/h2r_pkg.sv -----
// Shared types and constants for the HSV to RGB colour converter.
package h2r_pkg;

    typedef logic [12:0] t_hue;
    typedef logic [7:0]  t_chan;
    typedef logic [9:0]  t_frac;

    typedef enum logic [2:0] {
        SEC_RED_GREEN  = 3'd0,
        SEC_GREEN_RED  = 3'd1,
        SEC_GREEN_BLUE = 3'd2,
        SEC_BLUE_GREEN = 3'd3,
        SEC_BLUE_RED   = 3'd4,
        SEC_RED_BLUE   = 3'd5
    } t_sector;

    localparam int unsigned HUE_TURN    = 5760;
    localparam int unsigned HUE_SECTOR  = 960;
    localparam int unsigned NUM_SECTORS = 6;
    localparam int unsigned CHAN_MAX    = 255;

    // 244800 = 64 * 3825: drop six bits, then divide by 3825 via reciprocal
    localparam int unsigned RAMP_PRE_SHIFT = 6;
    localparam int unsigned RAMP_DIV_ODD   = 3825;
    localparam int unsigned RECIP_SHIFT    = 32;
    localparam longint unsigned RAMP_RECIP =
        ((64'd1 << RECIP_SHIFT) + RAMP_DIV_ODD - 1) / RAMP_DIV_ODD;

endpackage

// ----- hdl/h2r_if.sv -----
// Valid/ready channel interfaces for HSV input and RGB output transactions.
interface h2r_in_if;
    import h2r_pkg::*;

    logic  valid;
    logic  ready;
    t_hue  hue;
    t_chan saturation;
    t_chan brightness;

    modport source (output valid, output hue, output saturation, output brightness,
                    input ready);
    modport sink   (input valid, input hue, input saturation, input brightness,
                    output ready);
endinterface

interface h2r_out_if;
    import h2r_pkg::*;

    logic  valid;
    logic  ready;
    t_chan red;
    t_chan green;
    t_chan blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

// ----- hdl/hsv_to_rgb_converter.sv -----
// HSV to RGB colour converter: seven-stage pipeline, one pixel per clock while o_pix is taken.
//
// i_pix carries one HSV colour per transaction: hue in sixteenths of a degree
// (values of a full turn and above wrap once), saturation and brightness as
// fractions of 255. o_pix returns the matching 8-bit red, green and blue.
//
// Throughput is one transaction per cycle while o_pix is taken. The multipliers
// (brightness times saturation and times its complement, then times the hue
// weight) and the reciprocal multiply that divides the ramp numerator each sit
// in a stage of its own.
//
// All stages advance together. When o_pix holds a result the sink does not
// take, the whole pipeline holds and i_pix.ready drops in the same cycle; no
// transaction is lost or repeated. Empty slots hold along with the rest, so a
// bubble caught in a held pipeline is not squeezed out and later reaches
// o_pix as an idle cycle.
//
// Reset clears every stage valid bit; o_pix.valid is low in the cycle after a
// reset edge. The data registers are not reset.
module hsv_to_rgb_converter (
    input  logic         i_clk,
    input  logic         i_rst_n,
    h2r_in_if.sink       i_pix,
    h2r_out_if.source    o_pix
);
    import h2r_pkg::*;

    localparam int unsigned STAGES = 7;

    logic [STAGES-1:0] r_vld;
    logic [STAGES-1:0] n_vld;
    logic              w_adv;

    // stage 1: wrapped hue
    t_hue    r1_hue;
    t_chan   r1_s;
    t_chan   r1_v;
    t_hue    n1_hue;
    // stage 2: sector and offset
    t_sector r2_sec;
    t_frac   r2_f;
    t_chan   r2_s;
    t_chan   r2_ns;
    t_chan   r2_v;
    t_sector n2_sec;
    t_frac   n2_f;
    // stage 3: weight and products
    t_sector r3_sec;
    t_frac   r3_w;
    logic [15:0] r3_vs;
    logic [15:0] r3_vns;
    t_chan   r3_v;
    // stage 4: ramp terms and low value
    t_sector r4_sec;
    logic [25:0] r4_pw;
    logic [25:0] r4_base;
    t_chan   r4_low;
    t_chan   r4_v;
    logic [16:0] w4_low_sum;
    // stage 5: ramp numerator over 64
    t_sector r5_sec;
    logic [19:0] r5_x;
    t_chan   r5_low;
    t_chan   r5_v;
    logic [25:0] w5_num;
    // stage 6: ramp value
    t_sector r6_sec;
    t_chan   r6_ramp;
    t_chan   r6_low;
    t_chan   r6_v;
    logic [40:0] w6_prod;
    // stage 7: output
    t_chan   r7_red;
    t_chan   r7_green;
    t_chan   r7_blue;
    t_chan   n7_red;
    t_chan   n7_green;
    t_chan   n7_blue;

    assign w_adv       = !r_vld[STAGES-1] || o_pix.ready;
    assign i_pix.ready = w_adv;

    assign n_vld = {r_vld[STAGES-2:0], i_pix.valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= n_vld;
        end
    end

    always_comb begin
        if (i_pix.hue >= t_hue'(HUE_TURN)) begin
            n1_hue = i_pix.hue - t_hue'(HUE_TURN);
        end else begin
            n1_hue = i_pix.hue;
        end
    end

    // independent compares against each sector start; the highest match wins
    always_comb begin
        n2_sec = SEC_RED_GREEN;
        n2_f   = t_frac'(r1_hue);
        for (int unsigned j = 1; j < NUM_SECTORS; j++) begin
            if (r1_hue >= t_hue'(j * HUE_SECTOR)) begin
                n2_sec = t_sector'(3'(j));
                n2_f   = t_frac'(r1_hue - t_hue'(j * HUE_SECTOR));
            end
        end
    end

    // floor(x / 255) for x below 255 * 256, where it fits in eight bits
    assign w4_low_sum = 17'(r3_vns) + 17'(r3_vns[15:8]) + 17'd1;
    assign w5_num     = r4_pw + r4_base;
    assign w6_prod    = 41'(r5_x) * 41'(RAMP_RECIP);

    always_comb begin
        case (r6_sec)
            SEC_RED_GREEN: begin
                n7_red = r6_v;    n7_green = r6_ramp; n7_blue = r6_low;
            end
            SEC_GREEN_RED: begin
                n7_red = r6_ramp; n7_green = r6_v;    n7_blue = r6_low;
            end
            SEC_GREEN_BLUE: begin
                n7_red = r6_low;  n7_green = r6_v;    n7_blue = r6_ramp;
            end
            SEC_BLUE_GREEN: begin
                n7_red = r6_low;  n7_green = r6_ramp; n7_blue = r6_v;
            end
            SEC_BLUE_RED: begin
                n7_red = r6_ramp; n7_green = r6_low;  n7_blue = r6_v;
            end
            default: begin
                n7_red = r6_v;    n7_green = r6_low;  n7_blue = r6_ramp;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_hue   <= n1_hue;
            r1_s     <= i_pix.saturation;
            r1_v     <= i_pix.brightness;

            r2_sec   <= n2_sec;
            r2_f     <= n2_f;
            r2_s     <= r1_s;
            r2_ns    <= t_chan'(CHAN_MAX) - r1_s;
            r2_v     <= r1_v;

            r3_sec   <= r2_sec;
            r3_w     <= r2_sec[0] ? (t_frac'(HUE_SECTOR) - r2_f) : r2_f;
            r3_vs    <= 16'(r2_v) * 16'(r2_s);
            r3_vns   <= 16'(r2_v) * 16'(r2_ns);
            r3_v     <= r2_v;

            r4_sec   <= r3_sec;
            r4_pw    <= 26'(r3_vs) * 26'(r3_w);
            r4_base  <= (26'(r3_vns) << 10) - (26'(r3_vns) << 6);
            r4_low   <= w4_low_sum[15:8];
            r4_v     <= r3_v;

            r5_sec   <= r4_sec;
            r5_x     <= w5_num[25:RAMP_PRE_SHIFT];
            r5_low   <= r4_low;
            r5_v     <= r4_v;

            r6_sec   <= r5_sec;
            r6_ramp  <= w6_prod[RECIP_SHIFT+7:RECIP_SHIFT];
            r6_low   <= r5_low;
            r6_v     <= r5_v;

            r7_red   <= n7_red;
            r7_green <= n7_green;
            r7_blue  <= n7_blue;
        end
    end

    assign o_pix.valid = r_vld[STAGES-1];
    assign o_pix.red   = r7_red;
    assign o_pix.green = r7_green;
    assign o_pix.blue  = r7_blue;

    // a held result must block new input
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pix.valid && !o_pix.ready) |-> !i_pix.ready)
        else $error("input accepted while output stalled");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_pix.valid)
        else $error("output valid straight after reset");

    a_valid_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_vld[0]) |=> r_vld[1])
        else $error("transaction dropped between first stages");

    // ramp and low values lie between zero and brightness
    a_ramp_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[5] |-> (r6_ramp <= r6_v && r6_low <= r6_v))
        else $error("ramp or low value exceeds brightness");

    a_sector_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[1] |-> (r2_f < t_frac'(HUE_SECTOR)))
        else $error("hue offset outside its sector");

endmodule
